@@ rtl/core/load_switch_event_detector_macros.svh @@
// Assertion helpers shared by the detector RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef LOAD_SWITCH_EVENT_DETECTOR_MACROS_SVH
`define LOAD_SWITCH_EVENT_DETECTOR_MACROS_SVH

// Same-cycle implication.
`define LSED_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("load switch event detector: check failed");

// Next-cycle implication.
`define LSED_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("load switch event detector: check failed");

`endif

@@ rtl/core/lsed_pkg.sv @@
`default_nettype none
package lsed_pkg;

	localparam int TIME_W     = 32;
	localparam int POWER_W    = 20;
	localparam int THR_W      = 20;
	localparam int DELAY_W    = 24;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int DIFF_W     = POWER_W + 2;

	localparam logic [THR_W-1:0]   THR_RESET   = 20'd100;
	localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd0;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_DELAY     = 2'd1;

	typedef enum logic [KIND_W-1:0] {
		EV_ON1 = 3'd0,
		EV_ON2 = 3'd1,
		EV_ON3 = 3'd2,
		EV_ON4 = 3'd3,
		EV_OFF = 3'd4
	} event_kind_t;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_UP        = 3'd1,
		PH_UP_HOLD   = 3'd2,
		PH_DOWN      = 3'd3,
		PH_DOWN_HOLD = 3'd4,
		PH_DIP       = 3'd5,
		PH_DIP_LOW   = 3'd6,
		PH_AFTER     = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		CHG_RISE,
		CHG_FALL,
		CHG_STEADY,
		CHG_EDGE
	} chg_t;

	typedef struct packed {
		logic        fire;
		event_kind_t kind;
		phase_t      phase;
	} lsed_status_t;

endpackage
`default_nettype wire

@@ rtl/core/lsed_ifs.sv @@
`default_nettype none

interface lsed_sample_if import lsed_pkg::*;;
	logic               valid;
	logic               ready;
	logic [TIME_W-1:0]  sample_time;
	logic [POWER_W-1:0] active_power;

	modport source (output valid, output sample_time, output active_power, input ready);
	modport sink (input valid, input sample_time, input active_power, output ready);
endinterface

interface lsed_event_if import lsed_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] event_kind;
	logic [TIME_W-1:0] event_time;

	modport source (output valid, output event_kind, output event_time, input ready);
	modport sink (input valid, input event_kind, input event_time, output ready);
endinterface

interface lsed_cfg_if import lsed_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/load_switch_event_detector.sv @@
// Load switch event detector. Each word on the samples channel is a timestamped
// active-power reading (0.01 s and 0.1 W units). The change against the previous
// reading is classed as rise, fall or steady using change_threshold, and an
// eight-phase tracker turns the sequence of classes into appliance events
// (on1, on2, on3, on4, off), at most one event word per sample, carrying the
// triggering timestamp. A change of exactly minus the threshold leaves the phase
// alone. on4 needs the time since the settle mark to exceed settle_delay.
// Throughput is one sample per clock unless events.ready stalls the event
// register; a sample passes the input register, then the event register. The
// rate is set by the update of the phase and last-power registers, which each
// sample must see from the one before it. Write configuration over the cfg
// channel only while idle; the cfg channel is always ready.
`default_nettype none
module load_switch_event_detector import lsed_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	lsed_sample_if.sink  samples,
	lsed_event_if.source events,
	lsed_cfg_if.sink     cfg
);

	`include "load_switch_event_detector_macros.svh"

	logic               smp_valid_s1;
	logic [TIME_W-1:0]  smp_time_s1;
	logic [POWER_W-1:0] smp_power_s1;
	logic               ev_valid_q;
	event_kind_t        ev_kind_q;
	logic [TIME_W-1:0]  ev_time_q;
	logic               advance;
	logic               in_take;
	logic [THR_W-1:0]   change_threshold;
	logic [DELAY_W-1:0] settle_delay;
	lsed_status_t       status;

	// Configuration registers; every write is taken at once.
	assign cfg.ready = 1'b1;

	lsed_cfg_regs u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.wr_en            (cfg.valid),
		.wr_index         (cfg.index),
		.wr_data          (cfg.data),
		.change_threshold (change_threshold),
		.settle_delay     (settle_delay)
	);

	// Process the held sample when the event register is free or being drained.
	assign advance        = smp_valid_s1 && (!ev_valid_q || events.ready);
	assign samples.ready  = !smp_valid_s1 || advance;
	assign in_take        = samples.valid && samples.ready;

	// Input register: load on accept, drop once processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid_s1 <= 1'b0;
		end else if (in_take) begin
			smp_valid_s1 <= 1'b1;
		end else if (advance) begin
			smp_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			smp_time_s1  <= samples.sample_time;
			smp_power_s1 <= samples.active_power;
		end
	end

	// Classifier and phase tracker; state moves only on advance.
	lsed_tracker u_tracker (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.sample_time      (smp_time_s1),
		.active_power     (smp_power_s1),
		.change_threshold (change_threshold),
		.settle_delay     (settle_delay),
		.status           (status)
	);

	// Event register: hold while stalled, refill on advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (advance) begin
			ev_valid_q <= status.fire;
		end else if (events.ready) begin
			ev_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && status.fire) begin
			ev_kind_q <= status.kind;
			ev_time_q <= smp_time_s1;
		end
	end

	assign events.valid      = ev_valid_q;
	assign events.event_kind = ev_kind_q;
	assign events.event_time = ev_time_q;

	// A held sample that cannot advance must still be there next cycle.
	`LSED_ASSERT_NXT(a_hold_sample, smp_valid_s1 && !advance, smp_valid_s1)
	// An accepted word always lands in the input register.
	`LSED_ASSERT_NXT(a_take_lands, in_take, smp_valid_s1)
	// Every event leaves the tracker idle or in the after-settle phase.
	`LSED_ASSERT_NXT(a_fire_phase, advance && status.fire,
		status.phase == PH_IDLE || status.phase == PH_AFTER)
	// The event register only fills from a firing sample.
	`LSED_ASSERT_IMP(a_ev_source, $rose(ev_valid_q), $past(advance && status.fire))

endmodule
`default_nettype wire

@@ rtl/core/lsed_cfg_regs.sv @@
`default_nettype none
module lsed_cfg_regs import lsed_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output logic      [THR_W-1:0]      change_threshold,
	output logic      [DELAY_W-1:0]    settle_delay
);

	logic [THR_W-1:0]   threshold_q;
	logic [DELAY_W-1:0] delay_q;

	// Unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
			delay_q     <= DELAY_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_CHANGE_THRESHOLD: threshold_q <= wr_data[THR_W-1:0];
				REG_SETTLE_DELAY:     delay_q     <= wr_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	assign change_threshold = threshold_q;
	assign settle_delay     = delay_q;

endmodule
`default_nettype wire

@@ rtl/core/lsed_tracker.sv @@
`default_nettype none
module lsed_tracker import lsed_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [TIME_W-1:0]  sample_time,
	input  wire logic [POWER_W-1:0] active_power,
	input  wire logic [THR_W-1:0]   change_threshold,
	input  wire logic [DELAY_W-1:0] settle_delay,
	output lsed_status_t            status
);

	phase_t             phase_q, phase_nxt;
	logic [POWER_W-1:0] last_power_q;
	logic [TIME_W-1:0]  settle_start_q;
	logic signed [DIFF_W-1:0] diff, thr_pos, thr_neg;
	logic [TIME_W-1:0]  elapsed;
	logic               settled;
	logic               capture;
	logic               fire;
	event_kind_t        kind;
	chg_t               chg;

	assign diff    = $signed({2'b00, active_power}) - $signed({2'b00, last_power_q});
	assign thr_pos = $signed({{(DIFF_W-THR_W){1'b0}}, change_threshold});
	assign thr_neg = -thr_pos;
	assign elapsed = sample_time - settle_start_q;
	assign settled = (sample_time >= settle_start_q) &&
		(elapsed > {{(TIME_W-DELAY_W){1'b0}}, settle_delay});

	always_comb begin
		if (diff > thr_pos)
			chg = CHG_RISE;
		else if (diff < thr_neg)
			chg = CHG_FALL;
		else if (diff > thr_neg)
			chg = CHG_STEADY;
		else
			chg = CHG_EDGE;
	end

	// Next phase.
	always_comb begin
		phase_nxt = phase_q;
		case (chg)
			CHG_RISE: begin
				if (phase_q == PH_IDLE || phase_q == PH_UP_HOLD || phase_q == PH_DIP_LOW)
					phase_nxt = PH_UP;
			end
			CHG_FALL: begin
				case (phase_q)
					PH_IDLE:      phase_nxt = PH_DOWN;
					PH_UP:        phase_nxt = PH_DIP;
					PH_DOWN:      phase_nxt = PH_DIP;
					PH_DOWN_HOLD: phase_nxt = PH_DOWN;
					PH_DIP:       phase_nxt = PH_DIP_LOW;
					PH_DIP_LOW:   phase_nxt = PH_AFTER;
					default:      phase_nxt = phase_q;
				endcase
			end
			CHG_STEADY: begin
				case (phase_q)
					PH_UP:   phase_nxt = PH_UP_HOLD;
					PH_DOWN: phase_nxt = PH_DOWN_HOLD;
					PH_IDLE: phase_nxt = PH_IDLE;
					default: phase_nxt = PH_IDLE;
				endcase
			end
			default: phase_nxt = phase_q;
		endcase
	end

	// Event and settle capture.
	always_comb begin
		fire    = 1'b0;
		kind    = EV_ON1;
		capture = 1'b0;
		case (chg)
			CHG_FALL: begin
				if (phase_q == PH_DIP)
					capture = 1'b1;
				if (phase_q == PH_DIP_LOW && settled) begin
					fire = 1'b1;
					kind = EV_ON4;
				end
			end
			CHG_STEADY: begin
				case (phase_q)
					PH_UP_HOLD:   begin fire = 1'b1; kind = EV_ON1; end
					PH_DOWN_HOLD: begin fire = 1'b1; kind = EV_OFF; end
					PH_DIP:       begin fire = 1'b1; kind = EV_ON2; end
					PH_DIP_LOW:   begin fire = 1'b1; kind = EV_ON3; end
					PH_AFTER:     begin fire = 1'b1; kind = EV_OFF; end
					default:      fire = 1'b0;
				endcase
			end
			default: fire = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			last_power_q   <= '0;
			settle_start_q <= '0;
		end else if (step) begin
			phase_q      <= phase_nxt;
			last_power_q <= active_power;
			if (capture)
				settle_start_q <= sample_time;
		end
	end

	assign status.fire  = fire;
	assign status.kind  = kind;
	assign status.phase = phase_q;

endmodule
`default_nettype wire
